[rtl/ipcp_pkg.sv]
// ----------------------------------------------------------------------------
// ipcp_pkg
// Shared widths, payload structs, register codes, sequencer states and the
// saturate / clamp helpers of the interleaved phase current PI unit.
// ----------------------------------------------------------------------------
package ipcp_pkg;

    localparam int NUM_PHASES     = 3;
    localparam int DATA_WIDTH     = 24;
    localparam int GAIN_WIDTH     = 24;
    localparam int FRAC_SHIFT     = 16;
    localparam int PHASE_WIDTH    = 2;
    localparam int LIMIT_WIDTH    = DATA_WIDTH - 1;
    localparam int PHASE_IDX_W    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

    // error is one bit wider than the data, the multiplier operand two
    localparam int ERR_WIDTH      = DATA_WIDTH + 1;
    localparam int SUM_WIDTH      = DATA_WIDTH + 1;
    localparam int MUL_A_WIDTH    = DATA_WIDTH + 2;
    localparam int PROD_WIDTH     = MUL_A_WIDTH + GAIN_WIDTH + 1;
    localparam int SHIFT_WIDTH    = PROD_WIDTH - FRAC_SHIFT;
    localparam int ACC_WIDTH      = SHIFT_WIDTH + 1;

    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic signed [ACC_WIDTH-1:0] DATA_MAX_ACC =
        {{(ACC_WIDTH - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] DATA_MIN_ACC =
        {{(ACC_WIDTH - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

    typedef enum logic [1:0] {
        REG_PROP_GAIN       = 2'd0,
        REG_INTEG_GAIN      = 2'd1,
        REG_ANTIWINDUP_GAIN = 2'd2
    } ipcp_reg_idx_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] prop_gain;
        logic [GAIN_WIDTH-1:0] integ_gain;
        logic [GAIN_WIDTH-1:0] antiwindup_gain;
    } ipcp_gains_t;

    typedef struct packed {
        logic [PHASE_WIDTH-1:0]       phase;
        logic signed [DATA_WIDTH-1:0] measured_current;
        logic signed [DATA_WIDTH-1:0] current_ref;
        logic [LIMIT_WIDTH-1:0]       voltage_limit;
    } ipcp_sample_t;

    typedef struct packed {
        logic [PHASE_WIDTH-1:0]       phase_out;
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         clamped;
    } ipcp_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_ACC_I,
        ST_SUM,
        ST_MUL_W,
        ST_WRITE
    } ipcp_state_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_data(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic signed [DATA_WIDTH-1:0] r;
        begin
            if (v > DATA_MAX_ACC)
            begin
                r = DATA_MAX_ACC[DATA_WIDTH-1:0];
            end
            else if (v < DATA_MIN_ACC)
            begin
                r = DATA_MIN_ACC[DATA_WIDTH-1:0];
            end
            else
            begin
                r = v[DATA_WIDTH-1:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] clamp_lim(
        input logic signed [ACC_WIDTH-1:0] v,
        input logic [LIMIT_WIDTH-1:0]      lim
    );
        logic signed [ACC_WIDTH-1:0]  lim_pos;
        logic signed [ACC_WIDTH-1:0]  lim_neg;
        logic signed [DATA_WIDTH-1:0] r;
        begin
            lim_pos = signed'({{(ACC_WIDTH - LIMIT_WIDTH){1'b0}}, lim});
            lim_neg = -lim_pos;
            if (v > lim_pos)
            begin
                r = lim_pos[DATA_WIDTH-1:0];
            end
            else if (v < lim_neg)
            begin
                r = lim_neg[DATA_WIDTH-1:0];
            end
            else
            begin
                r = v[DATA_WIDTH-1:0];
            end
            return r;
        end
    endfunction

endpackage

[rtl/ipcp_apb_regs.sv]
// ----------------------------------------------------------------------------
// ipcp_apb_regs
// APB register file holding the proportional, integral and anti-windup gains.
// ----------------------------------------------------------------------------
module ipcp_apb_regs
    import ipcp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output ipcp_gains_t               gains
);

    ipcp_gains_t   gains_reg;
    ipcp_gains_t   gains_next;
    ipcp_reg_idx_t reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = ipcp_reg_idx_t'(paddr[3:2]);
    assign gains   = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PROP_GAIN:       gains_next.prop_gain       = pwdata[GAIN_WIDTH-1:0];
                REG_INTEG_GAIN:      gains_next.integ_gain      = pwdata[GAIN_WIDTH-1:0];
                REG_ANTIWINDUP_GAIN: gains_next.antiwindup_gain = pwdata[GAIN_WIDTH-1:0];
                default:             gains_next = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROP_GAIN:
                prdata = APB_DATA_WIDTH'(gains_reg.prop_gain);
            REG_INTEG_GAIN:
                prdata = APB_DATA_WIDTH'(gains_reg.integ_gain);
            REG_ANTIWINDUP_GAIN:
                prdata = APB_DATA_WIDTH'(gains_reg.antiwindup_gain);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

[rtl/ipcp_mul.sv]
// ----------------------------------------------------------------------------
// ipcp_mul
// Shared signed-by-gain multiplier with registered product; the output is
// the product shifted down by the gain fraction bits (floor).
// ----------------------------------------------------------------------------
module ipcp_mul
    import ipcp_pkg::*;
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [MUL_A_WIDTH-1:0] a,
    input  logic [GAIN_WIDTH-1:0]         b,
    output logic signed [SHIFT_WIDTH-1:0] q
);

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [GAIN_WIDTH:0]   b_signed;

    assign b_signed = signed'({1'b0, b});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b_signed;
        end
    end

    // dropping the low bits of a signed value is a floor shift
    assign q = prod_reg[PROD_WIDTH-1:FRAC_SHIFT];

endmodule

[rtl/interleaved_phase_current_pi_unit.sv]
// ----------------------------------------------------------------------------
// interleaved_phase_current_pi_unit
// Three-phase interleaved current PI with back-calculation anti-windup.
//
// sample channel (valid/ready): phase, measured current, reference and the
// symmetric voltage limit. result channel (valid/ready): phase, clamped drive
// and a flag that the PI sum hit the limit. One result beat per sample beat,
// in order. The user must write the gains over the APB port only while the
// unit is idle; the unit itself does not enforce this. Each sample runs
// through one shared multiplier under a small sequencer: P product, I
// product, integrator update, sum and clamp, anti-windup product, then the
// state write. A new sample is taken only once the sequencer is back in
// idle after the write, so the unit works on one sample at a time; the three
// multiplier passes and the add / clamp steps between them make up the
// sequence. A sample for a phase beyond the last one changes no state, goes
// straight to the write step and returns drive 0.
// The result sits in an output register, so a sample can be taken while it
// waits; if the receiver stalls longer, the write step holds until the
// register frees up. Reset clears the gains, every phase integrator and
// anti-windup term, and empties the output register.
// ----------------------------------------------------------------------------
module interleaved_phase_current_pi_unit
    import ipcp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  ipcp_sample_t              sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output ipcp_result_t              result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    ipcp_gains_t                   gains;
    ipcp_state_t                   state_reg;
    ipcp_state_t                   state_next;

    logic [PHASE_WIDTH-1:0]        phase_reg;
    logic                          phase_ok_reg;
    logic signed [ERR_WIDTH-1:0]   err_reg;
    logic [LIMIT_WIDTH-1:0]        limit_reg;
    logic signed [DATA_WIDTH-1:0]  p_reg;
    logic signed [DATA_WIDTH-1:0]  integ_reg;
    logic signed [SUM_WIDTH-1:0]   sum_reg;
    logic signed [DATA_WIDTH-1:0]  drive_reg;
    logic                          clip_reg;
    logic signed [MUL_A_WIDTH-1:0] diff_reg;

    logic signed [DATA_WIDTH-1:0]  integ_mem_reg   [NUM_PHASES];
    logic signed [DATA_WIDTH-1:0]  windup_mem_reg  [NUM_PHASES];

    ipcp_result_t                  result_reg;
    ipcp_result_t                  result_next;
    logic                          result_valid_reg;

    logic [PHASE_IDX_W-1:0]        idx;
    logic                          sample_beat;
    logic                          out_free;
    logic                          mul_en;
    logic                          load_out;
    logic signed [MUL_A_WIDTH-1:0] mul_a;
    logic [GAIN_WIDTH-1:0]         mul_b;
    logic signed [SHIFT_WIDTH-1:0] mul_q;

    logic signed [ERR_WIDTH-1:0]   err_in;
    logic signed [ACC_WIDTH-1:0]   integ_acc;
    logic signed [SUM_WIDTH-1:0]   sum_val;
    logic signed [DATA_WIDTH-1:0]  drive_val;
    logic signed [DATA_WIDTH-1:0]  lim_s;

    ipcp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    ipcp_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .q   (mul_q)
    );

    assign idx          = phase_reg[PHASE_IDX_W-1:0];
    assign sample_beat  = sample_valid & sample_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign lim_s        = signed'({1'b0, limit_reg});

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_beat)
                begin
                    if (32'(sample.phase) < NUM_PHASES)
                    begin
                        state_next = ST_MUL_P;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_ACC_I;
            ST_ACC_I: state_next = ST_SUM;
            ST_SUM:   state_next = ST_MUL_W;
            ST_MUL_W: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_ready = 1'b0;
        mul_en       = 1'b0;
        load_out     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            ST_MUL_P:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_WIDTH'(err_reg);
                mul_b  = gains.prop_gain;
            end
            ST_MUL_I:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_WIDTH'(err_reg) - MUL_A_WIDTH'(windup_mem_reg[idx]);
                mul_b  = gains.integ_gain;
            end
            ST_MUL_W:
            begin
                mul_en = 1'b1;
                mul_a  = diff_reg;
                mul_b  = gains.antiwindup_gain;
            end
            ST_WRITE:
            begin
                load_out = out_free;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    assign err_in    = ERR_WIDTH'(sample.current_ref) - ERR_WIDTH'(sample.measured_current);
    assign integ_acc = ACC_WIDTH'(integ_mem_reg[idx]) + ACC_WIDTH'(mul_q);
    assign sum_val   = SUM_WIDTH'(p_reg) + SUM_WIDTH'(integ_reg);
    assign drive_val = clamp_lim(ACC_WIDTH'(sum_val), limit_reg);

    always_ff @(posedge clk)
    begin
        if (sample_beat)
        begin
            phase_reg    <= sample.phase;
            phase_ok_reg <= (32'(sample.phase) < NUM_PHASES);
            err_reg      <= err_in;
            limit_reg    <= sample.voltage_limit;
        end
        if (state_reg == ST_MUL_I)
        begin
            p_reg <= sat_data(ACC_WIDTH'(mul_q));
        end
        if (state_reg == ST_ACC_I)
        begin
            integ_reg <= clamp_lim(integ_acc, limit_reg);
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg   <= sum_val;
            drive_reg <= drive_val;
            clip_reg  <= (sum_val != SUM_WIDTH'(drive_val));
            diff_reg  <= MUL_A_WIDTH'(sum_val) - MUL_A_WIDTH'(drive_val);
        end
    end

    // sum_reg kept for the drive check below; drive and diff are registered from the same sum
    always_comb
    begin
        result_next = result_reg;
        if (load_out)
        begin
            result_next.phase_out = phase_reg;
            if (phase_ok_reg)
            begin
                result_next.drive   = drive_reg;
                result_next.clamped = clip_reg;
            end
            else
            begin
                result_next.drive   = '0;
                result_next.clamped = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                integ_mem_reg[i]  <= '0;
                windup_mem_reg[i] <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (load_out && phase_ok_reg)
            begin
                integ_mem_reg[idx]  <= integ_reg;
                windup_mem_reg[idx] <= sat_data(ACC_WIDTH'(mul_q));
            end
        end
    end

    // ---------------------------------------------------------------- checks
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> state_reg == ST_IDLE)
        else $error("sample taken outside idle");

    a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> (integ_reg <= lim_s) && (integ_reg >= -lim_s))
        else $error("integrator outside clamp range");

    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && phase_ok_reg) |->
            (drive_reg <= lim_s) && (drive_reg >= -lim_s) &&
            ((sum_reg != SUM_WIDTH'(drive_reg)) == clip_reg))
        else $error("drive outside limit or clamp flag mismatch");

    a_bad_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !phase_ok_reg) |=> (result.drive == '0) && !result.clamped)
        else $error("out of range phase gave a nonzero drive");

    a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && !out_free) |=> $stable(mul_q))
        else $error("product changed while write step stalled");

endmodule

[tb/tb_interleaved_phase_current_pi_unit.sv]
// ----------------------------------------------------------------------------
// tb_interleaved_phase_current_pi_unit
// Self-checking bench for the interleaved phase current PI unit. Gains go in
// over APB while the unit is idle; sample beats come in bursts with random
// gaps while the result side stalls on its own pattern, with one long
// hold-off that backs the unit up. A per-phase PI model predicts every
// result beat and a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module tb_interleaved_phase_current_pi_unit;
    import ipcp_pkg::*;

    localparam int  DIRECT_PHASES   = NUM_PHASES;
    localparam int  REG_UNUSED_IDX  = 3;
    localparam int  RAND_SEGMENTS   = 8;
    localparam int  SEGMENT_ITEMS   = 212;
    localparam int  HOLD_CYCLES     = 300;
    localparam int  IDLE_LIMIT      = 5000;
    localparam int  MAX_PRINTED     = 20;
    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX  = '1;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE  = 24'h010000;
    localparam logic [GAIN_WIDTH-1:0] GAIN_TWO  = 24'h020000;
    localparam logic [GAIN_WIDTH-1:0] GAIN_8TH  = 24'h002000;
    localparam logic [DATA_WIDTH-1:0] D_MAX     = 24'h7FFFFF;
    localparam logic [DATA_WIDTH-1:0] D_MIN     = 24'h800000;
    localparam logic [LIMIT_WIDTH-1:0] LIM_MAX  = '1;

    // per-phase PI model plus the queue of drive beats it has predicted
    class pi_drive_predictor;
        logic [GAIN_WIDTH-1:0] kp;
        logic [GAIN_WIDTH-1:0] ki;
        logic [GAIN_WIDTH-1:0] ka;
        longint integ_acc [NUM_PHASES];
        longint windup_acc [NUM_PHASES];
        ipcp_result_t pending_drives [$];

        function void clear();
            kp = '0;
            ki = '0;
            ka = '0;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                integ_acc[i] = 0;
                windup_acc[i] = 0;
            end
            pending_drives.delete();
        endfunction

        function void load_gain(int idx, logic [31:0] v);
            case (idx)
                REG_PROP_GAIN:       kp = v[GAIN_WIDTH-1:0];
                REG_INTEG_GAIN:      ki = v[GAIN_WIDTH-1:0];
                REG_ANTIWINDUP_GAIN: ka = v[GAIN_WIDTH-1:0];
                default:             ;
            endcase
        endfunction

        function longint shift_floor(longint v);
            return v >>> FRAC_SHIFT;
        endfunction

        function longint saturate(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
            lo = -(longint'(1) <<< (DATA_WIDTH - 1));
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function longint limit_to(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void predict_drive(ipcp_sample_t s);
            ipcp_result_t e;
            longint meas;
            longint cur_ref;
            longint lim;
            longint err;
            longint p_term;
            longint i_term;
            longint pi_sum;
            longint drv;
            int idx;
            e.phase_out = s.phase;
            e.drive = '0;
            e.clamped = 1'b0;
            if (s.phase < NUM_PHASES)
            begin
                idx = int'(s.phase);
                meas = longint'(s.measured_current);
                cur_ref = longint'(s.current_ref);
                lim = longint'(s.voltage_limit);
                err = cur_ref - meas;
                p_term = saturate(shift_floor(err * longint'(kp)));
                i_term = integ_acc[idx] +
                         shift_floor((err - windup_acc[idx]) * longint'(ki));
                i_term = limit_to(i_term, lim);
                integ_acc[idx] = i_term;
                pi_sum = p_term + i_term;
                drv = limit_to(pi_sum, lim);
                windup_acc[idx] = saturate(shift_floor((pi_sum - drv) * longint'(ka)));
                e.drive = DATA_WIDTH'(drv);
                e.clamped = (pi_sum != drv);
            end
            pending_drives.push_back(e);
        endfunction

        function bit compare_drive(ipcp_result_t r, output string msg);
            ipcp_result_t e;
            msg = "";
            if (pending_drives.size() == 0)
            begin
                msg = $sformatf("result beat phase %0d drive %0d with nothing expected",
                                r.phase_out, r.drive);
                return 1'b0;
            end
            e = pending_drives.pop_front();
            if (r.phase_out !== e.phase_out)
                msg = {msg, $sformatf(" phase_out %0d/%0d", r.phase_out, e.phase_out)};
            if (r.drive !== e.drive)
                msg = {msg, $sformatf(" drive %0d/%0d", r.drive, e.drive)};
            if (r.clamped !== e.clamped)
                msg = {msg, $sformatf(" clamped %0b/%0b", r.clamped, e.clamped)};
            if (msg != "")
            begin
                msg = {"got/expected:", msg};
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_ready;
    ipcp_sample_t sample;
    logic result_valid;
    logic result_ready;
    ipcp_result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    pi_drive_predictor pi_model = new;
    int mismatches;
    int samples_seen;
    int results_seen;
    int gain_settings;
    int idle_count;
    bit hold_req;
    string check_msg;

    interleaved_phase_current_pi_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // sample and result beats are both seen here, sample first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                pi_model.predict_drive(sample);
                samples_seen++;
            end
            if (result_valid && result_ready)
            begin
                if (!pi_model.compare_drive(result, check_msg))
                    report_mismatch(check_msg);
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int len;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                repeat (HOLD_CYCLES) @(negedge clk) result_ready <= 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(4, 40);
                for (int i = 0; i < len; i++)
                begin
                    @(negedge clk);
                    case (mode)
                        0: result_ready <= 1'b1;
                        1: result_ready <= ($urandom_range(0, 1) == 1);
                        2: result_ready <= ($urandom_range(0, 3) == 0);
                        default: result_ready <= ((i % 5) < 2);
                    endcase
                end
            end
        end
    end

    task automatic send_sample(ipcp_sample_t s);
        @(negedge clk);
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    task automatic idle_gap(int n);
        repeat (n) @(negedge clk) sample_valid <= 1'b0;
    endtask

    task automatic apb_write(int idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_WIDTH'(idx * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pi_model.load_gain(idx, data);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // let every outstanding beat come back before touching the gains
    task automatic drain();
        idle_gap(1);
        while (pi_model.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] ka);
        drain();
        apb_write(REG_PROP_GAIN, kp);
        apb_write(REG_INTEG_GAIN, ki);
        apb_write(REG_ANTIWINDUP_GAIN, ka);
        gain_settings++;
    endtask

    function automatic ipcp_sample_t sample_of(logic [PHASE_WIDTH-1:0] ph,
                                               logic [DATA_WIDTH-1:0] cur_ref,
                                               logic [DATA_WIDTH-1:0] meas,
                                               logic [LIMIT_WIDTH-1:0] lim);
        ipcp_sample_t s;
        s.phase = ph;
        s.current_ref = cur_ref;
        s.measured_current = meas;
        s.voltage_limit = lim;
        return s;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3: return '1;
            default: return DATA_WIDTH'(1);
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        logic [7:0] junk;
        junk = 8'($urandom);
        case ($urandom_range(0, 5))
            0: return {junk, 24'h000000};
            1: return {junk, GAIN_MAX};
            2, 3: return {junk, 24'($urandom_range(0, 32'h030000))};
            default: return {junk, 24'($urandom)};
        endcase
    endfunction

    function automatic logic [LIMIT_WIDTH-1:0] random_limit();
        case ($urandom_range(0, 3))
            0: return LIMIT_WIDTH'($urandom_range(0, 4096));
            1: return LIMIT_WIDTH'($urandom_range(0, 262144));
            2: return LIMIT_WIDTH'($urandom);
            default: return LIM_MAX;
        endcase
    endfunction

    // mostly small, coherent errors so the integrator and windup paths get worked
    function automatic ipcp_sample_t random_sample(logic [LIMIT_WIDTH-1:0] base_lim);
        ipcp_sample_t s;
        int v_ref;
        int v_meas;
        int pick;
        pick = $urandom_range(0, 99);
        s.phase = (pick < 5) ? PHASE_WIDTH'(DIRECT_PHASES)
                             : PHASE_WIDTH'($urandom_range(0, NUM_PHASES - 1));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                s.current_ref = DATA_WIDTH'($urandom);
                s.measured_current = DATA_WIDTH'($urandom);
            end
            2, 3, 4, 5:
            begin
                v_ref = int'($urandom_range(0, 16383)) - 8192;
                v_meas = v_ref + int'($urandom_range(0, 511)) - 256;
                s.current_ref = DATA_WIDTH'(v_ref);
                s.measured_current = DATA_WIDTH'(v_meas);
            end
            6, 7, 8:
            begin
                v_ref = int'($urandom_range(0, 524288)) - 262144;
                v_meas = int'($urandom_range(0, 524288)) - 262144;
                s.current_ref = DATA_WIDTH'(v_ref);
                s.measured_current = DATA_WIDTH'(v_meas);
            end
            default:
            begin
                s.current_ref = extreme_value();
                s.measured_current = extreme_value();
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 80)
            s.voltage_limit = base_lim;
        else if (pick < 90)
            s.voltage_limit = LIMIT_WIDTH'($urandom);
        else if (pick < 95)
            s.voltage_limit = '0;
        else
            s.voltage_limit = LIM_MAX;
        return s;
    endfunction

    task automatic send_list(ipcp_sample_t items [$]);
        foreach (items[i])
        begin
            send_sample(items[i]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    task automatic run_random(int n, logic [LIMIT_WIDTH-1:0] base_lim);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < n; j++)
            begin
                send_sample(random_sample(base_lim));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 10));
        end
    endtask

    initial
    begin
        ipcp_sample_t items [$];
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        mismatches = 0;
        samples_seen = 0;
        results_seen = 0;
        gain_settings = 0;
        idle_count = 0;
        pi_model.clear();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset gains: everything should come back as zero drive
        items.delete();
        items.push_back(sample_of(2'd0, D_MAX, D_MIN, LIM_MAX));
        items.push_back(sample_of(2'd1, 24'h000100, 24'h000000, 23'h000080));
        items.push_back(sample_of(2'd2, D_MIN, D_MAX, 23'h000000));
        items.push_back(sample_of(PHASE_WIDTH'(DIRECT_PHASES), D_MAX, D_MIN, LIM_MAX));
        send_list(items);

        // a write past the last register must change nothing
        drain();
        apb_write(REG_UNUSED_IDX, 32'hFFFFFFFF);

        load_gains({8'hA5, GAIN_TWO}, {8'h5A, GAIN_8TH}, {8'hFF, GAIN_ONE});
        items.delete();
        items.push_back(sample_of(2'd0, D_MAX, D_MIN, LIM_MAX));
        items.push_back(sample_of(2'd1, D_MIN, D_MAX, LIM_MAX));
        items.push_back(sample_of(2'd2, 24'h000200, 24'h000180, 23'h010000));
        items.push_back(sample_of(2'd0, 24'h000200, 24'h000100, 23'h010000));
        items.push_back(sample_of(PHASE_WIDTH'(DIRECT_PHASES), D_MIN, D_MAX, 23'h000100));
        // zero limit, then zero limit with zero error
        items.push_back(sample_of(2'd1, 24'h001000, 24'h000000, 23'h000000));
        items.push_back(sample_of(2'd1, 24'h000400, 24'h000400, 23'h000000));
        // wind phase 2 into the limit, then reverse the error
        for (int i = 0; i < 4; i++)
            items.push_back(sample_of(2'd2, 24'h004000, 24'hFFC000, 23'h000800));
        for (int i = 0; i < 3; i++)
            items.push_back(sample_of(2'd2, 24'hFFF000, 24'h001000, 23'h000800));
        send_list(items);

        load_gains({8'h00, GAIN_MAX}, {8'h00, GAIN_MAX}, {8'h00, GAIN_MAX});
        items.delete();
        items.push_back(sample_of(2'd0, D_MAX, D_MIN, LIM_MAX));
        items.push_back(sample_of(2'd1, 24'h000003, 24'h000001, 23'h000040));
        items.push_back(sample_of(2'd2, 24'h000000, 24'h000000, LIM_MAX));
        items.push_back(sample_of(2'd0, D_MIN, D_MAX, LIM_MAX));
        send_list(items);

        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            if (seg == 0)
                load_gains({8'h3C, GAIN_MAX}, {8'hC3, GAIN_MAX}, {8'h0F, GAIN_MAX});
            else if (seg == 1)
                load_gains(32'h0, 32'h0, 32'h0);
            else
                load_gains(random_gain(), random_gain(), random_gain());
            // the unit backs up while the sender keeps offering
            if (seg == 2)
                hold_req = 1'b1;
            run_random(SEGMENT_ITEMS, random_limit());
        end

        idle_gap(1);
        while (pi_model.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d samples, %0d results, %0d gain settings", samples_seen,
                 results_seen, gain_settings);
        $display("covered saturation, zero limit, windup recovery and unused phase index");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
